FILE: src/mbbg_pkg.sv
// Shared types, opcodes and the 2x2 block rule for the block-cellular grid.
`timescale 1ns / 1ps

package mbbg_pkg;

	localparam int IDX_W = 7;
	localparam int IDX_COUNT = 128;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_wr;
		logic cell_rd;
		logic cell_wr;
		logic gen_start;
		logic wr0;
		logic wr1;
		logic rd_next;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic pair_last;
	} sts_t;

	// One 2x2 block: top-left, top-right, bottom-left, bottom-right.
	typedef struct packed {
		logic tl;
		logic tr;
		logic bl;
		logic br;
	} quad_t;

	function automatic quad_t block_rule(input quad_t q);
		logic [2:0] live;
		quad_t r;
		live = {2'b00, q.tl} + {2'b00, q.tr} + {2'b00, q.bl} + {2'b00, q.br};
		r = q;
		if (live == 3'd1) begin
			// A lone ball crosses to the opposite corner.
			r.tl = q.br;
			r.tr = q.bl;
			r.bl = q.tr;
			r.br = q.tl;
		end else if (live == 3'd2 && ((q.tl && q.br) || (q.tr && q.bl))) begin
			r.tl = ~q.tl;
			r.tr = ~q.tr;
			r.bl = ~q.bl;
			r.br = ~q.br;
		end
		return r;
	endfunction

endpackage

FILE: src/mbbg_ctrl.sv
// Controller state machine: request decode, clearing pass and generation sequencing.
`timescale 1ns / 1ps

module mbbg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [1:0]        opcode,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  mbbg_pkg::sts_t    sts,
	output mbbg_pkg::cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_CELL_WR = 7'b0000100,
		ST_RD_OUT  = 7'b0001000,
		ST_GEN_WR0 = 7'b0010000,
		ST_GEN_WR1 = 7'b0100000,
		ST_SPARE   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					case (mbbg_pkg::op_t'(opcode))
						mbbg_pkg::OP_WRITE: begin
							cmd.cell_rd = 1'b1;
							state_d     = ST_CELL_WR;
						end
						mbbg_pkg::OP_READ: begin
							cmd.cell_rd = 1'b1;
							state_d     = ST_RD_OUT;
						end
						mbbg_pkg::OP_STEP: begin
							cmd.gen_start = 1'b1;
							state_d       = ST_GEN_WR0;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_CELL_WR: begin
				cmd.cell_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_RD_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_GEN_WR0: begin
				cmd.wr0 = 1'b1;
				state_d = ST_GEN_WR1;
			end
			ST_GEN_WR1: begin
				cmd.wr1 = 1'b1;
				if (sts.pair_last) begin
					state_d = ST_IDLE;
				end else begin
					// The next row pair is read while the bottom row goes back.
					cmd.rd_next = 1'b1;
					state_d     = ST_GEN_WR0;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

FILE: src/mbbg_dpath.sv
// Datapath: grid memory, row addressing, cell access and the row-pair update logic.
`timescale 1ns / 1ps

module mbbg_dpath #(
	parameter int GRID_ROWS = 128,
	parameter int GRID_COLS = 128
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mbbg_pkg::IDX_W-1:0]   row_index,
	input  logic [mbbg_pkg::IDX_W-1:0]   column_index,
	input  logic                         cell_value,
	input  logic                         phase,
	input  mbbg_pkg::cmd_t               cmd,
	output mbbg_pkg::sts_t               sts,
	output logic                         read_value
);

	localparam int ROW_W = $clog2(GRID_ROWS);
	localparam int COL_W = $clog2(GRID_COLS);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
	localparam logic [ROW_W:0] ROW_COUNT = (ROW_W + 1)'(GRID_ROWS);
	localparam bit COLS_ODD = (GRID_COLS % 2) == 1;

	logic [GRID_COLS-1:0] mem_q [GRID_ROWS];
	logic [GRID_COLS-1:0] rowa_s1, rowb_s1;
	logic [ROW_W-1:0]     row_q, cell_row_q;
	logic [COL_W-1:0]     col_q;
	logic                 val_q, phase_q, read_value_q;

	logic [ROW_W-1:0]     row_mod, raddr_a, raddr_b, waddr;
	logic [COL_W-1:0]     col_mod;
	logic [ROW_W:0]       row_plus2;
	logic                 rd_en, we;
	logic [GRID_COLS-1:0] wdata, cell_row, gen_top1, gen_bot1, gen_top, gen_bot;
	logic [GRID_COLS-1:0] blk_act;
	mbbg_pkg::quad_t      blk_new [GRID_COLS];

	function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] x);
		return (x == ROW_LAST) ? '0 : x + ROW_W'(1);
	endfunction

	// Indexes beyond the grid fold back by a small constant table.
	always_comb begin
		row_mod = '0;
		col_mod = '0;
		for (int k = 0; k < mbbg_pkg::IDX_COUNT; k++) begin
			if (row_index == mbbg_pkg::IDX_W'(k)) begin
				row_mod = ROW_W'(k % GRID_ROWS);
			end
			if (column_index == mbbg_pkg::IDX_W'(k)) begin
				col_mod = COL_W'(k % GRID_COLS);
			end
		end
	end

	assign row_plus2 = {1'b0, row_q} + (ROW_W + 1)'(2);
	assign sts.pair_last = row_plus2 >= ROW_COUNT;
	assign sts.clr_last  = row_q == ROW_LAST;

	always_comb begin
		if (cmd.gen_start) begin
			raddr_a = ROW_W'(phase);
		end else if (cmd.rd_next) begin
			raddr_a = row_plus2[ROW_W-1:0];
		end else begin
			raddr_a = row_mod;
		end
	end

	assign raddr_b = row_inc(raddr_a);
	assign rd_en   = cmd.cell_rd | cmd.gen_start | cmd.rd_next;

	// Block update across one row pair, blocks starting at columns of the phase parity.
	for (genvar j = 0; j < GRID_COLS; j++) begin : g_blk
		localparam int J1 = (j + 1) % GRID_COLS;
		localparam bit J_PAR = (j % 2) == 1;
		localparam bit J_SKIP = COLS_ODD && (j == GRID_COLS - 1);
		assign blk_new[j] = mbbg_pkg::block_rule(
			{rowa_s1[j], rowa_s1[J1], rowb_s1[j], rowb_s1[J1]});
		assign blk_act[j] = (phase_q == J_PAR) && !J_SKIP;
	end

	for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
		localparam int CP = (c + GRID_COLS - 1) % GRID_COLS;
		assign gen_top1[c] = blk_act[c] ? blk_new[c].tl :
			blk_act[CP] ? blk_new[CP].tr : rowa_s1[c];
		assign gen_bot1[c] = blk_act[c] ? blk_new[c].bl :
			blk_act[CP] ? blk_new[CP].br : rowb_s1[c];
	end

	// With an odd width, the last block wraps onto column 0, which it sees already updated.
	if (COLS_ODD) begin : g_wrap
		mbbg_pkg::quad_t wq;
		assign wq = mbbg_pkg::block_rule({gen_top1[GRID_COLS-1], gen_top1[0],
			gen_bot1[GRID_COLS-1], gen_bot1[0]});
		always_comb begin
			gen_top = gen_top1;
			gen_bot = gen_bot1;
			if (!phase_q) begin
				gen_top[GRID_COLS-1] = wq.tl;
				gen_top[0]           = wq.tr;
				gen_bot[GRID_COLS-1] = wq.bl;
				gen_bot[0]           = wq.br;
			end
		end
	end else begin : g_nowrap
		assign gen_top = gen_top1;
		assign gen_bot = gen_bot1;
	end

	always_comb begin
		cell_row        = rowa_s1;
		cell_row[col_q] = val_q;
	end

	always_comb begin
		we    = 1'b0;
		waddr = row_q;
		wdata = '0;
		if (cmd.clr_wr) begin
			we = 1'b1;
		end else if (cmd.cell_wr) begin
			we    = 1'b1;
			waddr = cell_row_q;
			wdata = cell_row;
		end else if (cmd.wr0) begin
			we    = 1'b1;
			wdata = gen_top;
		end else if (cmd.wr1) begin
			we    = 1'b1;
			waddr = row_inc(row_q);
			wdata = gen_bot;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rowa_s1 <= mem_q[raddr_a];
			rowb_s1 <= mem_q[raddr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.clr_wr) begin
			row_q <= row_q + ROW_W'(1);
		end else if (cmd.gen_start) begin
			row_q <= ROW_W'(phase);
		end else if (cmd.rd_next) begin
			row_q <= row_plus2[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cell_rd) begin
			cell_row_q <= row_mod;
			col_q      <= col_mod;
			val_q      <= cell_value;
		end
		if (cmd.gen_start) begin
			phase_q <= phase;
		end
		if (cmd.out_load) begin
			read_value_q <= rowa_s1[col_q];
		end
	end

	assign read_value = read_value_q;

endmodule

FILE: src/margolus_billiard_ball_grid.sv
// Top level of the toroidal 2x2-block billiard grid with a stream request and result port.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser: opcode; tdata: row, column, value, phase
//  m_*      out  m_tvalid/m_tready   tdata: read_value
//
// A cell write merges the value into its row; a cell read loads the output register.
// A generation reads each row pair, then writes its top row and its bottom row back:
// the single write port of the grid memory takes one row per cycle.
// After reset a clearing pass writes zeros to every row; no request is taken then.
// A waiting result does not stop new requests; only a second read waits for it to leave.
`timescale 1ns / 1ps

module margolus_billiard_ball_grid #(
	parameter int GRID_ROWS = 128,
	parameter int GRID_COLS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // row_index[6:0], column_index[13:7], cell_value[14], phase[15]
	input  logic [1:0]  s_tuser,   // opcode[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // read_value[0], zero fill above
);

	mbbg_pkg::cmd_t cmd;
	mbbg_pkg::sts_t sts;
	logic           read_value;

	mbbg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbbg_dpath #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.row_index    (s_tdata[6:0]),
		.column_index (s_tdata[13:7]),
		.cell_value   (s_tdata[14]),
		.phase        (s_tdata[15]),
		.cmd          (cmd),
		.sts          (sts),
		.read_value   (read_value)
	);

	assign m_tdata = {7'b0000000, read_value};

	// Only one row may be written to the grid in a cycle.
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_wr, cmd.cell_wr, cmd.wr0, cmd.wr1}))
		else $error("more than one grid write in a cycle");

	// A cell write request finishes with its merge write in the next cycle.
	a_cell_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == mbbg_pkg::OP_WRITE) |=> cmd.cell_wr)
		else $error("cell write request not written back");

	// The top row of a pair is always followed by its bottom row.
	a_pair_wr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr0 |=> cmd.wr1)
		else $error("row pair write broken");

	// A taken request with a real opcode blocks the next one while the controller is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser != mbbg_pkg::OP_NONE) |=> !s_tready)
		else $error("request taken while busy");

endmodule
